/* design/dpid_pkg.sv */
// ----------------------------------------------------------------------------
// dpid_pkg
// Shared types and constants of the drive PID controller: register map,
// move modes, gains, zone limits and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package dpid_pkg;

    // Field widths fixed by the register and result formats
    localparam int HEADING_W  = 24;
    localparam int TARGET_W   = 16;
    localparam int VEL_W      = 8;
    localparam int DRIVE_W    = 15;
    localparam int INTEG_W    = 12;
    localparam int VLIMIT_W   = 14;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_MOVE_MODE    = 3'd0;
    localparam logic [2:0] REG_DRIFT_ENABLE = 3'd1;
    localparam logic [2:0] REG_TARGET_COUNT = 3'd2;
    localparam logic [2:0] REG_MAX_VELOCITY = 3'd3;
    localparam logic [2:0] REG_HEADING_BASE = 3'd4;

    typedef enum logic [1:0] {
        MODE_FORWARD    = 2'd0,
        MODE_BACKWARD   = 2'd1,
        MODE_TURN_RIGHT = 2'd2,
        MODE_TURN_LEFT  = 2'd3
    } move_mode_t;

    typedef struct packed {
        move_mode_t                   move_mode;
        logic                         drift_enable;
        logic [TARGET_W-1:0]          target_count;
        logic [VEL_W-1:0]             max_velocity;
        logic signed [HEADING_W-1:0]  heading_base;
    } cfg_t;

    // Fixed point scale: one unit is 2^Q_TURN in turns, 2^Q_STRAIGHT straight
    localparam int Q_TURN     = 16;
    localparam int Q_STRAIGHT = 17;

    // Gains: straight kP = 29 * 2^15, kD = 13 * 2^16; turn kP = 6, kD = 30 (x 2^16)
    localparam int KP_STR_Q15 = 29;
    localparam int KD_STR     = 13;
    localparam int KP_TRN     = 6;
    localparam int KD_TRN     = 30;
    localparam int GAIN_SHIFT = 16;
    localparam int KI_Q16     = 655;

    localparam int ZONE_STRAIGHT = 250;
    localparam int ZONE_TURN     = 500;
    localparam int SIDE_LIMIT    = 12000;
    localparam int DRIFT_GAIN    = 5;

    // Voltage limit: ((4 * max_velocity) / 5) * 60, the /5 done as *205 >> 10
    localparam int VEL_RECIP    = 205;
    localparam int VEL_RECIP_SH = 10;
    localparam int VOLT_PER_VEL = 60;

endpackage

`default_nettype wire

/* design/dpid_if.sv */
// ----------------------------------------------------------------------------
// dpid_in_if / dpid_out_if
// Valid/ready channels of the drive PID controller: sensor samples in,
// side drive commands out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpid_in_if #(
    parameter int SENSOR_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic                          first_sample;
    logic signed [SENSOR_BITS-1:0] right_count;
    logic signed [SENSOR_BITS-1:0] left_count;
    logic signed [SENSOR_BITS-1:0] heading_now;

    modport source (
        output valid, first_sample, right_count, left_count, heading_now,
        input  ready
    );
    modport sink (
        input  valid, first_sample, right_count, left_count, heading_now,
        output ready
    );
endinterface

interface dpid_out_if import dpid_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;

    modport source (
        output valid, right_drive, left_drive,
        input  ready
    );
    modport sink (
        input  valid, right_drive, left_drive,
        output ready
    );
endinterface

`default_nettype wire

/* design/dpid_apb_regs.sv */
// ----------------------------------------------------------------------------
// dpid_apb_regs
// APB register file for move configuration; also derives the registered
// command voltage limit from max_velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module dpid_apb_regs import dpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg,
    output logic [VLIMIT_W-1:0]   volt_limit
);

    cfg_t                cfg_reg;
    logic [VLIMIT_W-1:0] volt_limit_reg;
    logic [VLIMIT_W-1:0] volt_limit_next;
    logic [17:0]         vel_prod;
    logic [VEL_W-1:0]    vel_q;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    assign vel_prod        = 18'({cfg_reg.max_velocity, 2'b00}) * 18'(VEL_RECIP);
    assign vel_q           = vel_prod[VEL_RECIP_SH +: VEL_W];
    assign volt_limit_next = VLIMIT_W'(vel_q) * VLIMIT_W'(VOLT_PER_VEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            volt_limit_reg <= '0;
        end
        else
        begin
            volt_limit_reg <= volt_limit_next;
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_MOVE_MODE:    cfg_reg.move_mode    <= move_mode_t'(pwdata[1:0]);
                    REG_DRIFT_ENABLE: cfg_reg.drift_enable <= pwdata[0];
                    REG_TARGET_COUNT: cfg_reg.target_count <= pwdata[TARGET_W-1:0];
                    REG_MAX_VELOCITY: cfg_reg.max_velocity <= pwdata[VEL_W-1:0];
                    REG_HEADING_BASE: cfg_reg.heading_base <= pwdata[HEADING_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MOVE_MODE:    prdata = {30'b0, cfg_reg.move_mode};
            REG_DRIFT_ENABLE: prdata = {31'b0, cfg_reg.drift_enable};
            REG_TARGET_COUNT: prdata = {16'b0, cfg_reg.target_count};
            REG_MAX_VELOCITY: prdata = {24'b0, cfg_reg.max_velocity};
            REG_HEADING_BASE: prdata = {{8{cfg_reg.heading_base[HEADING_W-1]}},
                                        cfg_reg.heading_base};
            default:          prdata = '0;
        endcase
    end

    assign cfg        = cfg_reg;
    assign volt_limit = volt_limit_reg;

endmodule

`default_nettype wire

/* design/dpid_error_unit.sv */
// ----------------------------------------------------------------------------
// dpid_error_unit
// Error against target, integral zone with symmetric clamp, and derivative
// for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dpid_error_unit import dpid_pkg::*;
#(
    parameter int SENSOR_BITS = 24
)
(
    input  cfg_t                                  cfg,
    input  logic                                  first_sample,
    input  logic signed [SENSOR_BITS-1:0]         right_count,
    input  logic signed [SENSOR_BITS-1:0]         left_count,
    input  logic signed [SENSOR_BITS-1:0]         heading_now,
    input  logic signed [INTEG_W-1:0]             integral_cur,
    input  logic signed [((SENSOR_BITS > HEADING_W) ? SENSOR_BITS : HEADING_W) + 1:0]
                                                  prev_error,
    output logic signed [((SENSOR_BITS > HEADING_W) ? SENSOR_BITS : HEADING_W) + 1:0]
                                                  err,
    output logic signed [((SENSOR_BITS > HEADING_W) ? SENSOR_BITS : HEADING_W) + 2:0]
                                                  deriv,
    output logic signed [INTEG_W-1:0]             integral_next,
    output logic signed [((SENSOR_BITS > HEADING_W) ? SENSOR_BITS : HEADING_W):0]
                                                  head_delta
);

    localparam int DW = ((SENSOR_BITS > HEADING_W) ? SENSOR_BITS : HEADING_W) + 1;
    localparam int EW = DW + 1;

    logic                    turn;
    logic [SENSOR_BITS:0]    sum_rl;
    logic [SENSOR_BITS:0]    abs_rl;
    logic [EW-1:0]           err_str;
    logic [DW-1:0]           abs_dh;
    logic [EW-1:0]           err_trn;
    logic signed [EW-1:0]    zone_v;
    logic                    in_zone;
    logic signed [INTEG_W-1:0] integ_in;
    logic signed [EW-1:0]    prev_in;
    logic signed [INTEG_W:0] acc;
    logic signed [INTEG_W:0] acc_sat;
    logic signed [INTEG_W:0] lim;

    assign turn = (cfg.move_mode == MODE_TURN_RIGHT) || (cfg.move_mode == MODE_TURN_LEFT);

    // Straight: error in half ticks against the mean of both encoders
    assign sum_rl  = {right_count[SENSOR_BITS-1], right_count}
                   + {left_count[SENSOR_BITS-1], left_count};
    assign abs_rl  = sum_rl[SENSOR_BITS] ? (~sum_rl + 1'b1) : sum_rl;
    assign err_str = {{(EW-TARGET_W-1){1'b0}}, cfg.target_count, 1'b0}
                   - {{(EW-SENSOR_BITS-1){1'b0}}, abs_rl};

    // Turn: error in centidegrees against heading change
    assign head_delta = {{(DW-SENSOR_BITS){heading_now[SENSOR_BITS-1]}}, heading_now}
                      - {{(DW-HEADING_W){cfg.heading_base[HEADING_W-1]}}, cfg.heading_base};
    assign abs_dh  = head_delta[DW-1] ? (~head_delta + 1'b1) : head_delta;
    assign err_trn = {{(EW-TARGET_W){1'b0}}, cfg.target_count} - {1'b0, abs_dh};

    assign err = turn ? err_trn : err_str;

    assign zone_v  = turn ? EW'(ZONE_TURN) : EW'(ZONE_STRAIGHT);
    assign in_zone = (err < zone_v) && (err > -zone_v);

    assign integ_in = first_sample ? '0 : integral_cur;
    assign prev_in  = first_sample ? '0 : prev_error;

    // Only meaningful inside the zone, where the error is small
    assign acc = {integ_in[INTEG_W-1], integ_in} + err[INTEG_W:0];
    assign lim = turn ? $signed({4'b0, cfg.max_velocity, 1'b0})
                      : $signed({3'b0, cfg.max_velocity, 2'b00});

    always_comb
    begin
        if (acc > lim)
            acc_sat = lim;
        else if (acc < -lim)
            acc_sat = -lim;
        else
            acc_sat = acc;
    end

    assign integral_next = in_zone ? acc_sat[INTEG_W-1:0] : '0;

    // Hold the derivative at zero once on target
    assign deriv = (err == '0) ? '0
                 : ({err[EW-1], err} - {prev_in[EW-1], prev_in});

endmodule

`default_nettype wire

/* design/drive_pid_controller_core.sv */
// ----------------------------------------------------------------------------
// drive_pid_controller_core
// Drive and turn PID controller for a two-sided drivetrain.
//
// Usage: software sets move_mode, drift_enable, target_count, max_velocity
// and heading_base over APB while the block is idle, then streams control
// samples (encoder counts and gyro heading) on the input channel. Each
// sample yields exactly one item with the right and left drive commands in
// millivolts, saturated to +-12000. Set first_sample on the first sample of
// a move to clear the integral and the previous error.
//
// Pipeline: an accepted item passes the input register, the error/integral
// stage and the drive stage into the result register. Throughput: one item
// per cycle while results are taken; the integral and previous error
// update in the single error stage, so back-to-back samples chain.
// When the receiver stalls, the whole pipeline holds and input ready drops
// only while a result waits untaken. Reset clears configuration, the
// integral, the previous error and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_pid_controller_core import dpid_pkg::*;
#(
    parameter int SENSOR_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    dpid_in_if.sink               in,
    dpid_out_if.source            out
);

    localparam int DW = ((SENSOR_BITS > HEADING_W) ? SENSOR_BITS : HEADING_W) + 1;
    localparam int EW = DW + 1;
    localparam int FW = EW + 23;
    localparam int SW = FW + 1;

    cfg_t                cfg;
    logic [VLIMIT_W-1:0] volt_limit;
    logic                advance;
    logic                turn;

    // Input register
    logic                          s0_valid_reg;
    logic                          s0_first_reg;
    logic signed [SENSOR_BITS-1:0] s0_right_reg;
    logic signed [SENSOR_BITS-1:0] s0_left_reg;
    logic signed [SENSOR_BITS-1:0] s0_head_reg;

    // Loop state
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [INTEG_W-1:0] integral_next;
    logic signed [EW-1:0]      prev_error_reg;

    // Error stage outputs and register
    logic signed [EW-1:0]      err_next;
    logic signed [EW:0]        deriv_next;
    logic signed [DW-1:0]      dh_next;
    logic                      m_valid_reg;
    logic signed [EW-1:0]      m_err_reg;
    logic signed [EW:0]        m_deriv_reg;
    logic signed [INTEG_W-1:0] m_integ_reg;
    logic signed [DW-1:0]      m_dh_reg;

    // Drive stage
    logic signed [FW-1:0] err_x;
    logic signed [FW-1:0] deriv_x;
    logic signed [FW-1:0] p_term;
    logic signed [FW-1:0] i_term;
    logic signed [FW-1:0] d_term;
    logic signed [FW-1:0] f_sum;
    logic signed [FW-1:0] vmax;
    logic signed [FW-1:0] f_cl;
    logic signed [SW-1:0] f_s;
    logic signed [SW-1:0] pd;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] l_sum;

    // Result register
    logic                      o_valid_reg;
    logic signed [DRIVE_W-1:0] o_right_reg;
    logic signed [DRIVE_W-1:0] o_left_reg;
    logic signed [DRIVE_W-1:0] o_right_next;
    logic signed [DRIVE_W-1:0] o_left_next;

    // Truncate toward zero to whole millivolts, then saturate
    function automatic logic [DRIVE_W-1:0] side_out(input logic signed [SW-1:0] sum,
                                                    input logic turn_mode);
        logic signed [SW-1:0] biased;
        logic signed [SW-1:0] q;
        biased = sum;
        if (sum < 0)
            biased = sum + (turn_mode ? SW'((1 << Q_TURN) - 1)
                                      : SW'((1 << Q_STRAIGHT) - 1));
        q = turn_mode ? (biased >>> Q_TURN) : (biased >>> Q_STRAIGHT);
        if (q > SW'(SIDE_LIMIT))
            return DRIVE_W'(SIDE_LIMIT);
        else if (q < -SW'(SIDE_LIMIT))
            return DRIVE_W'(-SIDE_LIMIT);
        else
            return q[DRIVE_W-1:0];
    endfunction

    dpid_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cfg        (cfg),
        .volt_limit (volt_limit)
    );

    assign pready = 1'b1;

    // Advance the whole pipeline unless a result waits untaken
    assign advance  = !o_valid_reg || out.ready;
    assign in.ready = advance;

    assign turn = (cfg.move_mode == MODE_TURN_RIGHT) || (cfg.move_mode == MODE_TURN_LEFT);

    dpid_error_unit #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_err (
        .cfg           (cfg),
        .first_sample  (s0_first_reg),
        .right_count   (s0_right_reg),
        .left_count    (s0_left_reg),
        .heading_now   (s0_head_reg),
        .integral_cur  (integral_reg),
        .prev_error    (prev_error_reg),
        .err           (err_next),
        .deriv         (deriv_next),
        .integral_next (integral_next),
        .head_delta    (dh_next)
    );

    always_comb
    begin
        err_x   = FW'(m_err_reg);
        deriv_x = FW'(m_deriv_reg);
        if (turn)
        begin
            p_term = (err_x * FW'(KP_TRN)) <<< GAIN_SHIFT;
            d_term = (deriv_x * FW'(KD_TRN)) <<< GAIN_SHIFT;
            vmax   = $signed(FW'(volt_limit)) <<< Q_TURN;
        end
        else
        begin
            p_term = (err_x * FW'(KP_STR_Q15)) <<< (GAIN_SHIFT - 1);
            d_term = (deriv_x * FW'(KD_STR)) <<< GAIN_SHIFT;
            vmax   = $signed(FW'(volt_limit)) <<< Q_STRAIGHT;
        end
        i_term = FW'(m_integ_reg) * FW'(KI_Q16);
        f_sum  = p_term + i_term + d_term;

        if (f_sum > vmax)
            f_cl = vmax;
        else if (f_sum < -vmax)
            f_cl = -vmax;
        else
            f_cl = f_sum;

        f_s = SW'(f_cl);
        pd  = (cfg.drift_enable && !turn)
            ? ((SW'(m_dh_reg) * SW'(DRIFT_GAIN)) <<< Q_STRAIGHT) : '0;

        case (cfg.move_mode)
            MODE_FORWARD:
            begin
                r_sum = f_s + pd;
                l_sum = f_s - pd;
            end
            MODE_BACKWARD:
            begin
                r_sum = -f_s + pd;
                l_sum = -f_s - pd;
            end
            MODE_TURN_RIGHT:
            begin
                r_sum = -f_s;
                l_sum = f_s;
            end
            default:
            begin
                r_sum = f_s;
                l_sum = -f_s;
            end
        endcase

        o_right_next = side_out(r_sum, turn);
        o_left_next  = side_out(l_sum, turn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
            integral_reg   <= '0;
            prev_error_reg <= '0;
        end
        else if (advance)
        begin
            s0_valid_reg <= in.valid;
            m_valid_reg  <= s0_valid_reg;
            o_valid_reg  <= m_valid_reg;
            if (s0_valid_reg)
            begin
                integral_reg   <= integral_next;
                prev_error_reg <= err_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_first_reg <= in.first_sample;
            s0_right_reg <= in.right_count;
            s0_left_reg  <= in.left_count;
            s0_head_reg  <= in.heading_now;
            m_err_reg    <= err_next;
            m_deriv_reg  <= deriv_next;
            m_integ_reg  <= integral_next;
            m_dh_reg     <= dh_next;
            o_right_reg  <= o_right_next;
            o_left_reg   <= o_left_next;
        end
    end

    assign out.valid       = o_valid_reg;
    assign out.right_drive = o_right_reg;
    assign out.left_drive  = o_left_reg;

endmodule

`default_nettype wire

/* design/dpid_checker.sv */
// ----------------------------------------------------------------------------
// dpid_checker
// Port-level checks of the drive PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpid_checker import dpid_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [DRIVE_W-1:0] right_drive,
    input logic signed [DRIVE_W-1:0] left_drive
);

    // Both sides stay inside the saturation window
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_drive >= -SIDE_LIMIT) && (right_drive <= SIDE_LIMIT)
                   && (left_drive >= -SIDE_LIMIT) && (left_drive <= SIDE_LIMIT))
        else $error("drive command outside saturation limit");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_drive) && $stable(left_drive))
        else $error("stalled result changed");

    // Input is held off only while a result waits untaken
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind drive_pid_controller_core dpid_checker u_dpid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .right_drive (out.right_drive),
    .left_drive  (out.left_drive)
);

`default_nettype wire
